### rtl/core/pscp_pkg.sv
// Shared types and constants for the protobuf slot-count parser.
package pscp_pkg;

  localparam int unsigned MAX_BODY_BYTES_DEF = 65536;
  localparam int unsigned QDEPTH = 2;

  localparam logic [12:0] DEF_SLOTS     = 13'd14;
  localparam logic [6:0]  DEF_MAX_CAT   = 7'd64;
  localparam logic [6:0]  DEF_MAX_CNT   = 7'd64;
  localparam logic [12:0] TOTAL_MAX     = 13'd8191;
  localparam logic [6:0]  CAT_SAT       = 7'd127;

  localparam logic [1:0] CFG_DEFAULT_SLOTS = 2'd0;
  localparam logic [1:0] CFG_MAX_CAT       = 2'd1;
  localparam logic [1:0] CFG_MAX_CNT       = 2'd2;

  localparam logic [2:0] WT_VARINT = 3'd0;
  localparam logic [2:0] WT_FIX64  = 3'd1;
  localparam logic [2:0] WT_LEN    = 3'd2;
  localparam logic [2:0] WT_FIX32  = 3'd5;

  typedef enum logic [2:0] {
    PH_TAG,
    PH_VAL,
    PH_SKIP,
    PH_LEN,
    PH_ITAG,
    PH_IVAL
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [12:0] default_slots;
    logic [6:0]  max_cat;
    logic [6:0]  max_cnt;
  } cfg_t;

endpackage

### rtl/core/pscp_front.sv
// Input stage: accepts words, drops empty ones and queues the rest.
module pscp_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,
  input  logic             in_tuser,
  input  logic             in_tlast,
  output logic             q_valid,
  output pscp_pkg::item_t  q_item,
  input  logic             q_pop
);

  pscp_pkg::item_t q_r [pscp_pkg::QDEPTH];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       pop;

  assign in_tready = (cnt_r != 2'(pscp_pkg::QDEPTH));
  assign push      = in_tvalid && in_tready && (in_tuser || in_tlast);
  assign q_valid   = (cnt_r != 2'd0);
  assign pop       = q_pop && q_valid;
  assign q_item    = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= '{data: in_tdata, valid: in_tuser, last: in_tlast};
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(pscp_pkg::QDEPTH)) else $error("queue count out of range");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 2'd1) else $error("queue count lost push");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |-> !pop) else $error("pop from empty queue");
`endif

endmodule

### rtl/core/pscp_back.sv
// Parse engine: decodes one queued byte per cycle unless a last word meets an untaken result; registers the result.
module pscp_back #(
  parameter int unsigned MAX_BODY_BYTES = pscp_pkg::MAX_BODY_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  pscp_pkg::cfg_t   cfg,
  input  logic             q_valid,
  input  pscp_pkg::item_t  q_item,
  output logic             q_pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [31:0]      out_tdata,
  output logic             out_tuser
);

  localparam int unsigned LW = $clog2(MAX_BODY_BYTES + 1);
  localparam int unsigned AW = (LW > 8) ? LW : 8;

  pscp_pkg::phase_t phase_r, phase_nxt;
  logic [AW-1:0] acc_lo_r, acc_lo_nxt;
  logic          acc_hi_r, acc_hi_nxt;
  logic [3:0]    idx_r, idx_nxt;
  logic          tagm_r, tagm_nxt;
  logic [LW-1:0] orem_r, orem_nxt;
  logic [LW-1:0] irem_r, irem_nxt;
  logic [6:0]    cat_r, cat_nxt;
  logic [6:0]    cnt_lo_r, cnt_lo_nxt;
  logic          cnt_big_r, cnt_big_nxt;
  logic [12:0]   total_r, total_nxt;
  logic          err_r, err_nxt;
  logic [LW-1:0] bcnt_r, bcnt_nxt;

  logic          ov_r, ov_nxt;
  logic [12:0]   slot_r, slot_nxt;
  logic [12:0]   tot_r, tot_nxt;
  logic          ok_r, ok_nxt;

  logic [7:0]    b;
  logic [6:0]    sh;
  logic [AW+6:0] contrib;
  logic          hi_add;
  logic [AW-1:0] v_lo;
  logic          v_hi;
  logic          ferr;
  logic          done;
  logic          v_zero;
  logic          v_big;
  logic          fin;
  logic [LW-1:0] irem_dec;
  logic [13:0]   sum;
  logic          ok;
  logic [12:0]   tot_o;

  assign q_pop = q_valid && (!q_item.last || !ov_r || out_tready);
  assign b     = q_item.data;

  always_comb begin
    sh      = {3'b000, idx_r} * 7'd7;
    contrib = (AW + 7)'(b[6:0]) << sh;
    hi_add  = (sh >= 7'(AW)) ? (b[6:0] != 7'd0) : (|contrib[AW+6:AW]);
    v_lo    = acc_lo_r | contrib[AW-1:0];
    v_hi    = acc_hi_r | hi_add;
    ferr    = (idx_r > 4'd9) || ((idx_r == 4'd9) && (b[7:1] != 7'd0));
    done    = !b[7];
    v_zero  = !v_hi && (v_lo == '0);
    v_big   = v_hi || (v_lo > AW'(MAX_BODY_BYTES));
    irem_dec = (irem_r != '0) ? irem_r - LW'(1) : irem_r;
  end

  always_comb begin
    phase_nxt   = phase_r;
    acc_lo_nxt  = acc_lo_r;
    acc_hi_nxt  = acc_hi_r;
    idx_nxt     = idx_r;
    tagm_nxt    = tagm_r;
    orem_nxt    = orem_r;
    irem_nxt    = irem_r;
    cat_nxt     = cat_r;
    cnt_lo_nxt  = cnt_lo_r;
    cnt_big_nxt = cnt_big_r;
    total_nxt   = total_r;
    err_nxt     = err_r;
    bcnt_nxt    = bcnt_r;
    ov_nxt      = ov_r && !out_tready;
    slot_nxt    = slot_r;
    tot_nxt     = tot_r;
    ok_nxt      = ok_r;
    fin         = 1'b0;
    sum         = '0;
    ok          = 1'b0;
    tot_o       = '0;

    if (q_pop && q_item.valid) begin
      if (bcnt_r >= LW'(MAX_BODY_BYTES)) begin
        err_nxt = 1'b1;
      end else begin
        bcnt_nxt = bcnt_r + LW'(1);
        if (!err_r) begin
          if (phase_r == pscp_pkg::PH_ITAG || phase_r == pscp_pkg::PH_IVAL) begin
            irem_nxt = irem_dec;
          end
          if (phase_r == pscp_pkg::PH_SKIP) begin
            orem_nxt = (orem_r != '0) ? orem_r - LW'(1) : orem_r;
            if (orem_nxt == '0) phase_nxt = pscp_pkg::PH_TAG;
          end else if (ferr) begin
            err_nxt = 1'b1;
          end else if (!done) begin
            acc_lo_nxt = v_lo;
            acc_hi_nxt = v_hi;
            idx_nxt    = idx_r + 4'd1;
            if ((phase_r == pscp_pkg::PH_ITAG || phase_r == pscp_pkg::PH_IVAL) &&
                irem_dec == '0) begin
              err_nxt = 1'b1;
            end
          end else begin
            acc_lo_nxt = '0;
            acc_hi_nxt = 1'b0;
            idx_nxt    = 4'd0;
            unique case (phase_r)
              pscp_pkg::PH_TAG: begin
                tagm_nxt = !v_hi && (v_lo[AW-1:3] == (AW - 3)'(3));
                case (v_lo[2:0])
                  pscp_pkg::WT_VARINT: phase_nxt = pscp_pkg::PH_VAL;
                  pscp_pkg::WT_FIX64: begin
                    orem_nxt  = LW'(8);
                    phase_nxt = pscp_pkg::PH_SKIP;
                  end
                  pscp_pkg::WT_FIX32: begin
                    orem_nxt  = LW'(4);
                    phase_nxt = pscp_pkg::PH_SKIP;
                  end
                  pscp_pkg::WT_LEN: phase_nxt = pscp_pkg::PH_LEN;
                  default: err_nxt = 1'b1;
                endcase
              end
              pscp_pkg::PH_VAL: phase_nxt = pscp_pkg::PH_TAG;
              pscp_pkg::PH_LEN: begin
                if (v_big) begin
                  err_nxt = 1'b1;
                end else if (tagm_r) begin
                  cat_nxt = (cat_r < pscp_pkg::CAT_SAT) ? cat_r + 7'd1 : cat_r;
                  if (cat_nxt > cfg.max_cat) begin
                    err_nxt = 1'b1;
                  end else begin
                    cnt_lo_nxt  = 7'd0;
                    cnt_big_nxt = 1'b0;
                    if (v_zero) begin
                      fin       = 1'b1;
                      phase_nxt = pscp_pkg::PH_TAG;
                    end else begin
                      irem_nxt  = LW'(v_lo);
                      phase_nxt = pscp_pkg::PH_ITAG;
                    end
                  end
                end else if (v_zero) begin
                  phase_nxt = pscp_pkg::PH_TAG;
                end else begin
                  orem_nxt  = LW'(v_lo);
                  phase_nxt = pscp_pkg::PH_SKIP;
                end
              end
              pscp_pkg::PH_ITAG: begin
                if (v_lo[2:0] != pscp_pkg::WT_VARINT || irem_dec == '0) begin
                  err_nxt = 1'b1;
                end else begin
                  tagm_nxt  = !v_hi && (v_lo[AW-1:3] == (AW - 3)'(2));
                  phase_nxt = pscp_pkg::PH_IVAL;
                end
              end
              pscp_pkg::PH_IVAL: begin
                if (tagm_r) begin
                  cnt_lo_nxt  = v_lo[6:0];
                  cnt_big_nxt = v_hi || (|v_lo[AW-1:7]);
                end
                if (irem_dec == '0) begin
                  fin       = 1'b1;
                  phase_nxt = pscp_pkg::PH_TAG;
                end else begin
                  phase_nxt = pscp_pkg::PH_ITAG;
                end
              end
              default: err_nxt = 1'b1;
            endcase
          end
        end
      end
    end

    if (fin) begin
      if (cnt_big_nxt || cnt_lo_nxt > cfg.max_cnt) begin
        err_nxt = 1'b1;
      end else begin
        sum       = {1'b0, total_r} + 14'(cnt_lo_nxt);
        total_nxt = (sum > 14'(pscp_pkg::TOTAL_MAX)) ? pscp_pkg::TOTAL_MAX : sum[12:0];
      end
    end

    if (q_pop && q_item.last) begin
      ok       = !err_nxt && phase_nxt == pscp_pkg::PH_TAG && idx_nxt == 4'd0;
      tot_o    = ok ? total_nxt : 13'd0;
      ov_nxt   = 1'b1;
      tot_nxt  = tot_o;
      ok_nxt   = ok;
      slot_nxt = (tot_o > cfg.default_slots) ? tot_o : cfg.default_slots;
      phase_nxt   = pscp_pkg::PH_TAG;
      acc_lo_nxt  = '0;
      acc_hi_nxt  = 1'b0;
      idx_nxt     = 4'd0;
      tagm_nxt    = 1'b0;
      orem_nxt    = '0;
      irem_nxt    = '0;
      cat_nxt     = 7'd0;
      cnt_lo_nxt  = 7'd0;
      cnt_big_nxt = 1'b0;
      total_nxt   = 13'd0;
      err_nxt     = 1'b0;
      bcnt_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= pscp_pkg::PH_TAG;
      acc_lo_r  <= '0;
      acc_hi_r  <= 1'b0;
      idx_r     <= 4'd0;
      tagm_r    <= 1'b0;
      orem_r    <= '0;
      irem_r    <= '0;
      cat_r     <= 7'd0;
      cnt_lo_r  <= 7'd0;
      cnt_big_r <= 1'b0;
      total_r   <= 13'd0;
      err_r     <= 1'b0;
      bcnt_r    <= '0;
      ov_r      <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      acc_lo_r  <= acc_lo_nxt;
      acc_hi_r  <= acc_hi_nxt;
      idx_r     <= idx_nxt;
      tagm_r    <= tagm_nxt;
      orem_r    <= orem_nxt;
      irem_r    <= irem_nxt;
      cat_r     <= cat_nxt;
      cnt_lo_r  <= cnt_lo_nxt;
      cnt_big_r <= cnt_big_nxt;
      total_r   <= total_nxt;
      err_r     <= err_nxt;
      bcnt_r    <= bcnt_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    tot_r  <= tot_nxt;
    ok_r   <= ok_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {6'd0, tot_r, slot_r};
  assign out_tuser  = ok_r;

`ifndef SYNTHESIS
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !ok_r) |-> tot_r == 13'd0) else $error("failed parse reports a total");
  a_slot_floor: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (slot_r >= tot_r)) else $error("slot count below total");
  a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_item.last) |=> ov_r) else $error("last word gave no result");
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= 4'd9) else $error("varint index out of range");
`endif

endmodule

### rtl/core/protobuf_slot_count_parser.sv
// Top level of the protobuf slot-count parser: config registers, input queue, parse engine.
// Takes one body byte per cycle while the queue has room; out_tvalid for a word with last
// set comes from the input queue register, then the result register, after that word is accepted.
// Bytes that do not end a body keep flowing while a result waits; a second last word holds in
// the two-entry queue until the waiting result is taken, and input stalls once the queue is
// full. Words with in_tuser and in_tlast both low are dropped at the input.
module protobuf_slot_count_parser #(
  parameter int unsigned MAX_BODY_BYTES = pscp_pkg::MAX_BODY_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tuser,   // byte_valid
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // slot_count[12:0], requested_total[25:13], zero fill
  output logic        out_tuser,  // parse_ok
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  pscp_pkg::cfg_t  cfg_r, cfg_nxt;
  pscp_pkg::item_t q_item;
  logic            q_valid;
  logic            q_pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        pscp_pkg::CFG_DEFAULT_SLOTS: cfg_nxt.default_slots = cfg_data;
        pscp_pkg::CFG_MAX_CAT:       cfg_nxt.max_cat       = cfg_data[6:0];
        pscp_pkg::CFG_MAX_CNT:       cfg_nxt.max_cnt       = cfg_data[6:0];
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{default_slots: pscp_pkg::DEF_SLOTS,
                 max_cat:       pscp_pkg::DEF_MAX_CAT,
                 max_cnt:       pscp_pkg::DEF_MAX_CNT};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pscp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  pscp_back #(
    .MAX_BODY_BYTES (MAX_BODY_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
